[hw/rtl/bcrop_pkg.sv]
// ----------------------------------------------------------------------------
// bcrop_pkg: shared types and constants of the 24-bit BMP crop stream
// Window limits, the decoded window geometry and the queued command format.
// ----------------------------------------------------------------------------
package bcrop_pkg;

    localparam int BMP_MAX_WIDTH  = 4096;
    localparam int BMP_MAX_HEIGHT = 4096;
    localparam int QUEUE_DEPTH    = 4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CROP_X     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CROP_Y     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CROP_W     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CROP_H     = 3'd5;

    // Window geometry derived from the configuration registers.
    typedef struct packed {
        logic        bad;        // a size is out of range or the window does not fit
        logic [15:0] row_bytes;  // stored source row size, padding included
        logic [15:0] x_lo;       // first kept byte of a row
        logic [15:0] x_hi;       // one past the last kept byte of a row
        logic [11:0] y_lo;       // first kept row
        logic [13:0] y_end;      // one past the last kept row
        logic [12:0] src_height;
        logic [1:0]  out_pad;    // padding bytes after each output row
    } geom_t;

    // One classified input byte, handed from the front to the back.
    typedef struct packed {
        logic       bad;
        logic [7:0] data;
        logic [1:0] pad_cnt;     // padding bytes to insert after this byte
        logic       row_last;
        logic       img_row;     // byte lies in the last kept row
    } cmd_t;

    // Result flags as they travel in m_tuser, is_pad in bit 0.
    typedef struct packed {
        logic window_bad;
        logic image_end;
        logic row_end;
        logic is_pad;
    } flags_t;

endpackage

[hw/rtl/bcrop_cfg.sv]
// ----------------------------------------------------------------------------
// bcrop_cfg: configuration registers and window decode
// Holds the six window registers and derives the byte-level geometry.
// ----------------------------------------------------------------------------
module bcrop_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [bcrop_pkg::CFG_IDX_W-1:0]   wr_index,
    input  logic [bcrop_pkg::CFG_DATA_W-1:0]  wr_data,
    output bcrop_pkg::geom_t                  geom
);
    import bcrop_pkg::*;

    logic [12:0] src_width_reg;
    logic [12:0] src_height_reg;
    logic [11:0] crop_x_reg;
    logic [11:0] crop_y_reg;
    logic [12:0] crop_w_reg;
    logic [12:0] crop_h_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= 13'd1;
            src_height_reg <= 13'd1;
            crop_x_reg     <= 12'd0;
            crop_y_reg     <= 12'd0;
            crop_w_reg     <= 13'd1;
            crop_h_reg     <= 13'd1;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_SRC_WIDTH:  src_width_reg  <= wr_data;
                REG_SRC_HEIGHT: src_height_reg <= wr_data;
                REG_CROP_X:     crop_x_reg     <= wr_data[11:0];
                REG_CROP_Y:     crop_y_reg     <= wr_data[11:0];
                REG_CROP_W:     crop_w_reg     <= wr_data;
                REG_CROP_H:     crop_h_reg     <= wr_data;
                default:        ;
            endcase
        end
    end

    logic [13:0] x_end;
    logic [13:0] y_end;
    logic [15:0] src_bytes;
    logic [1:0]  crop_bytes;

    always_comb
    begin
        x_end      = 14'(crop_x_reg) + 14'(crop_w_reg);
        y_end      = 14'(crop_y_reg) + 14'(crop_h_reg);
        // Multiplication by three as shift and add.
        src_bytes  = {2'b00, src_width_reg, 1'b0} + 16'(src_width_reg);
        // Only the low two bits of the output row size matter for its padding.
        crop_bytes = {crop_w_reg[0], 1'b0} + crop_w_reg[1:0];

        geom.bad = (src_width_reg == 13'd0)
                || (32'(src_width_reg) > 32'(BMP_MAX_WIDTH))
                || (src_height_reg == 13'd0)
                || (32'(src_height_reg) > 32'(BMP_MAX_HEIGHT))
                || (crop_w_reg == 13'd0)
                || (32'(crop_w_reg) > 32'(BMP_MAX_WIDTH))
                || (crop_h_reg == 13'd0)
                || (32'(crop_h_reg) > 32'(BMP_MAX_HEIGHT))
                || (x_end > 14'(src_width_reg))
                || (y_end > 14'(src_height_reg));

        geom.row_bytes  = (src_bytes + 16'd3) & ~16'd3;
        geom.x_lo       = {3'b000, crop_x_reg, 1'b0} + 16'(crop_x_reg);
        geom.x_hi       = {1'b0, x_end, 1'b0} + 16'(x_end);
        geom.y_lo       = crop_y_reg;
        geom.y_end      = y_end;
        geom.src_height = src_height_reg;
        geom.out_pad    = 2'd0 - crop_bytes;
    end

endmodule

[hw/rtl/bcrop_front.sv]
// ----------------------------------------------------------------------------
// bcrop_front: position tracking and byte classification
// Counts byte and row position of each byte; queues kept ones, all if bad.
// ----------------------------------------------------------------------------
module bcrop_front (
    input  logic              clk,
    input  logic              rst_n,
    input  bcrop_pkg::geom_t  geom,
    input  logic              accept,
    input  logic [7:0]        in_byte,
    input  logic              first,
    output logic              push,
    output bcrop_pkg::cmd_t   cmd
);
    import bcrop_pkg::*;

    logic [13:0] row_byte_pos_reg;
    logic [13:0] row_byte_pos_next;
    logic [11:0] row_index_reg;
    logic [11:0] row_index_next;

    logic [13:0] p;
    logic [11:0] r;
    logic        in_win;
    logic        row_last;

    always_comb
    begin
        p = first ? 14'd0 : row_byte_pos_reg;
        r = first ? 12'd0 : row_index_reg;

        in_win = (r >= geom.y_lo) && (14'(r) < geom.y_end)
              && (16'(p) >= geom.x_lo) && (16'(p) < geom.x_hi);
        row_last = (16'(p) == geom.x_hi - 16'd1);

        cmd.bad      = geom.bad;
        cmd.data     = in_byte;
        cmd.row_last = row_last;
        cmd.img_row  = (14'(r) == geom.y_end - 14'd1);
        cmd.pad_cnt  = (row_last && !geom.bad) ? geom.out_pad : 2'd0;

        push = accept && (geom.bad || in_win);

        // An invalid window freezes the counters, apart from a restart.
        row_byte_pos_next = p;
        row_index_next    = r;
        if (!geom.bad)
        begin
            if (16'(p) + 16'd1 >= geom.row_bytes)
            begin
                row_byte_pos_next = 14'd0;
                if (13'(r) + 13'd1 >= geom.src_height)
                    row_index_next = 12'd0;
                else
                    row_index_next = r + 12'd1;
            end
            else
            begin
                row_byte_pos_next = p + 14'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_byte_pos_reg <= 14'd0;
            row_index_reg    <= 12'd0;
        end
        else if (accept)
        begin
            row_byte_pos_reg <= row_byte_pos_next;
            row_index_reg    <= row_index_next;
        end
    end

endmodule

[hw/rtl/bcrop_queue.sv]
// ----------------------------------------------------------------------------
// bcrop_queue: short command queue between front and back
// A small circular buffer with a fill count and a combinational head.
// ----------------------------------------------------------------------------
module bcrop_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  bcrop_pkg::cmd_t   push_data,
    input  logic              pop,
    output logic              full,
    output logic              empty,
    output bcrop_pkg::cmd_t   head
);
    import bcrop_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + PTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule

[hw/rtl/bcrop_back.sv]
// ----------------------------------------------------------------------------
// bcrop_back: result generation and output register
// Expands each queued command into one byte plus any row padding.
// ----------------------------------------------------------------------------
module bcrop_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              empty,
    input  bcrop_pkg::cmd_t   head,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,
    output logic              m_tlast,
    output logic [3:0]        m_tuser
);
    import bcrop_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic [7:0] data_next;
    logic       last_reg;
    logic       last_next;
    flags_t     flags_reg;
    flags_t     flags_next;
    logic [1:0] pads_reg;
    logic [1:0] pads_next;

    logic out_free;
    logic fin;

    always_comb
    begin
        out_free   = !valid_reg || m_tready;
        fin        = (pads_reg == 2'd1);
        pop        = 1'b0;
        valid_next = valid_reg;
        data_next  = data_reg;
        last_next  = last_reg;
        flags_next = flags_reg;
        pads_next  = pads_reg;

        if (out_free)
        begin
            valid_next = !empty;
            if (!empty)
            begin
                flags_next = '0;
                if (pads_reg == 2'd0)
                begin
                    data_next = head.data;
                    if (head.bad)
                    begin
                        data_next             = 8'h00;
                        last_next             = 1'b1;
                        flags_next.window_bad = 1'b1;
                        pop                   = 1'b1;
                    end
                    else if (head.pad_cnt != 2'd0)
                    begin
                        last_next = 1'b0;
                        pads_next = head.pad_cnt;
                    end
                    else
                    begin
                        last_next            = 1'b1;
                        flags_next.row_end   = head.row_last;
                        flags_next.image_end = head.row_last && head.img_row;
                        pop                  = 1'b1;
                    end
                end
                else
                begin
                    data_next            = 8'h00;
                    last_next            = fin;
                    flags_next.is_pad    = 1'b1;
                    flags_next.row_end   = fin;
                    flags_next.image_end = fin && head.img_row;
                    pads_next            = pads_reg - 2'd1;
                    pop                  = fin;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pads_reg  <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            pads_reg  <= pads_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg  <= data_next;
        last_reg  <= last_next;
        flags_reg <= flags_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = flags_reg;

endmodule

[hw/rtl/bmp24_crop_stream.sv]
// ----------------------------------------------------------------------------
// bmp24_crop_stream: window crop of a 24-bit BMP pixel-data byte stream
// Keeps the bytes inside the configured window and pads output rows.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes the stored pixel-data bytes of the source image,
//   source row padding included, one byte per transfer; s_tuser marks the
//   first byte of an image and restarts the row and byte counters.
//   The master channel delivers the kept bytes. After the last kept byte of
//   each output row the block inserts zero bytes that round that row up to a
//   multiple of four; m_tlast closes the results caused by one input byte.
//   When a size is out of range or the window does not fit the source, every
//   input byte yields one result with the window_bad flag and no data.
//   The configuration channel writes the six window registers (index 0 to 5:
//   src_width, src_height, crop_x, crop_y, crop_w, crop_h); write it only
//   while no transfer is in flight.
// Timing:
//   An input transfer passes the command queue and then the output register.
//   The block takes one byte per cycle while the queue has room; a row-end
//   byte with padding yields two to four results, which the four-entry
//   command queue between the classifier and the result stage absorbs.
//   A stalled receiver holds the output register; input keeps flowing until
//   the queue fills, then s_tready drops.
//   Reset clears the counters and the queue and loads the register defaults.
// ----------------------------------------------------------------------------
module bmp24_crop_stream (
    input  logic                              clk,
    input  logic                              rst_n,
    // Input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] in_byte
    input  logic                              s_tuser,   // [0] first
    // Output stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,   // [7:0] out_byte
    output logic                              m_tlast,   // run_last
    output logic [3:0]                        m_tuser,   // [0] is_pad, [1] row_end,
                                                         // [2] image_end, [3] window_bad
    // Configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bcrop_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bcrop_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bcrop_pkg::*;

    geom_t geom;
    cmd_t  front_cmd;
    cmd_t  head_cmd;
    logic  push;
    logic  pop;
    logic  q_full;
    logic  q_empty;
    logic  in_accept;

    // Registers are always writable; the channel never stalls.
    assign cfg_ready = 1'b1;

    // A byte is taken whenever the queue has room, even if it causes no result.
    assign s_tready  = !q_full;
    assign in_accept = s_tvalid && s_tready;

    bcrop_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .geom     (geom)
    );

    bcrop_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .geom    (geom),
        .accept  (in_accept),
        .in_byte (s_tdata),
        .first   (s_tuser),
        .push    (push),
        .cmd     (front_cmd)
    );

    bcrop_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (front_cmd),
        .pop       (pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (head_cmd)
    );

    bcrop_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (q_empty),
        .head     (head_cmd),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
